/* src/uer_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg
// Shared widths, register indexes, reset values and types of the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned CNT_W   = 18;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned SUB_W   = 6;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  // one centimetre of range is 58 ticks of echo
  localparam int unsigned TICKS_PER_CM = 58;
  localparam logic [DIST_W-1:0]  MAX_CM   = 10'd999;
  localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TRIG_LOW  = 3'd0;
  localparam logic [IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
  localparam logic [IDX_W-1:0] REG_WAIT_LIM  = 3'd2;
  localparam logic [IDX_W-1:0] REG_HIGH_LIM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAP       = 3'd4;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd5;

  localparam logic [CNT_W-1:0]  RST_TRIG_LOW  = 18'd1000;
  localparam logic [CNT_W-1:0]  RST_TRIG_HIGH = 18'd1000;
  localparam logic [CNT_W-1:0]  RST_WAIT_LIM  = 18'd50000;
  localparam logic [CNT_W-1:0]  RST_HIGH_LIM  = 18'd50000;
  localparam logic [CNT_W-1:0]  RST_GAP       = 18'd200000;
  localparam logic [DIST_W-1:0] RST_THRESHOLD = 10'd20;

  typedef struct packed {
    logic [CNT_W-1:0]  trig_low;
    logic [CNT_W-1:0]  trig_high;
    logic [CNT_W-1:0]  wait_limit;
    logic [CNT_W-1:0]  high_limit;
    logic [CNT_W-1:0]  gap;
    logic [DIST_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic               trigger;
    logic               done_res;
    logic [DIST_W-1:0]  distance_cm;
    logic               timed_out;
    logic [DIGIT_W-1:0] hundreds_digit;
    logic [DIGIT_W-1:0] tens_digit;
    logic [DIGIT_W-1:0] ones_digit;
  } result_t;

endpackage
`default_nettype wire

/* src/uer_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uer_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module uer_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [uer_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [uer_pkg::CNT_W-1:0]   cfg_data,
  output uer_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trig_low   <= uer_pkg::RST_TRIG_LOW;
      cfg.trig_high  <= uer_pkg::RST_TRIG_HIGH;
      cfg.wait_limit <= uer_pkg::RST_WAIT_LIM;
      cfg.high_limit <= uer_pkg::RST_HIGH_LIM;
      cfg.gap        <= uer_pkg::RST_GAP;
      cfg.threshold  <= uer_pkg::RST_THRESHOLD;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        uer_pkg::REG_TRIG_LOW:  cfg.trig_low   <= cfg_data;
        uer_pkg::REG_TRIG_HIGH: cfg.trig_high  <= cfg_data;
        uer_pkg::REG_WAIT_LIM:  cfg.wait_limit <= cfg_data;
        uer_pkg::REG_HIGH_LIM:  cfg.high_limit <= cfg_data;
        uer_pkg::REG_GAP:       cfg.gap        <= cfg_data;
        uer_pkg::REG_THRESHOLD: cfg.threshold  <= cfg_data[uer_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/uer_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uer_seq
// Phase sequencer: trigger timing, echo wait, echo width count and report.
// ----------------------------------------------------------------------------
module uer_seq (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire logic     echo,
  input  wire uer_pkg::cfg_t cfg,
  output uer_pkg::result_t res
);

  localparam int unsigned PH_W = 3;
  localparam logic [PH_W-1:0] PH_TRIG_LOW  = 3'd0;
  localparam logic [PH_W-1:0] PH_TRIG_HIGH = 3'd1;
  localparam logic [PH_W-1:0] PH_WAIT      = 3'd2;
  localparam logic [PH_W-1:0] PH_MEASURE   = 3'd3;
  localparam logic [PH_W-1:0] PH_GAP       = 3'd4;

  localparam logic [uer_pkg::SUB_W-1:0] SUB_LAST =
    uer_pkg::SUB_W'(uer_pkg::TICKS_PER_CM - 1);

  logic [PH_W-1:0]             phase, phase_next;
  logic [uer_pkg::CNT_W-1:0]   phase_count, phase_count_next;
  logic [uer_pkg::CNT_W-1:0]   high_count, high_count_next;
  // running quotient of the echo width: ticks within the current cm, then cm
  logic [uer_pkg::SUB_W-1:0]   sub_count, sub_count_next;
  logic [uer_pkg::DIST_W-1:0]  cm, cm_next;
  logic [uer_pkg::DIGIT_W-1:0] cm_h, cm_h_next, cm_t, cm_t_next, cm_o, cm_o_next;
  logic [uer_pkg::DIST_W-1:0]  last_dist, last_dist_next;
  logic [uer_pkg::DIGIT_W-1:0] last_h, last_h_next, last_t, last_t_next;
  logic [uer_pkg::DIGIT_W-1:0] last_o, last_o_next;
  logic                        last_timeout, last_timeout_next;

  logic [uer_pkg::CNT_W-1:0]   pc_inc, hc_inc;
  logic [uer_pkg::DIST_W-1:0]  cm_inc;
  logic [uer_pkg::DIGIT_W-1:0] cm_h_inc, cm_t_inc, cm_o_inc;
  logic [PH_W-1:0]             after_report;
  logic                        trig, done;

  assign pc_inc = phase_count + 1'b1;
  assign hc_inc = high_count + 1'b1;
  assign after_report = (cfg.gap == '0) ? PH_TRIG_LOW : PH_GAP;

  // saturating binary and decimal increment of the centimetre count
  always_comb begin
    cm_inc   = cm;
    cm_h_inc = cm_h;
    cm_t_inc = cm_t;
    cm_o_inc = cm_o;
    if (cm != uer_pkg::MAX_CM) begin
      cm_inc = cm + 1'b1;
      if (cm_o == uer_pkg::MAX_DIGIT) begin
        cm_o_inc = '0;
        if (cm_t == uer_pkg::MAX_DIGIT) begin
          cm_t_inc = '0;
          cm_h_inc = cm_h + 1'b1;
        end else begin
          cm_t_inc = cm_t + 1'b1;
        end
      end else begin
        cm_o_inc = cm_o + 1'b1;
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    phase_count_next  = phase_count;
    high_count_next   = high_count;
    sub_count_next    = sub_count;
    cm_next           = cm;
    cm_h_next         = cm_h;
    cm_t_next         = cm_t;
    cm_o_next         = cm_o;
    last_dist_next    = last_dist;
    last_h_next       = last_h;
    last_t_next       = last_t;
    last_o_next       = last_o;
    last_timeout_next = last_timeout;
    trig              = 1'b0;
    done              = 1'b0;
    unique case (phase)
      PH_TRIG_LOW: begin
        phase_count_next = pc_inc;
        if (pc_inc >= cfg.trig_low) begin
          phase_next       = PH_TRIG_HIGH;
          phase_count_next = '0;
        end
      end
      PH_TRIG_HIGH: begin
        trig             = 1'b1;
        phase_count_next = pc_inc;
        if (pc_inc >= cfg.trig_high) begin
          phase_next       = PH_WAIT;
          phase_count_next = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          // rising tick is not counted
          phase_next       = PH_MEASURE;
          phase_count_next = '0;
          high_count_next  = '0;
          sub_count_next   = '0;
          cm_next          = '0;
          cm_h_next        = '0;
          cm_t_next        = '0;
          cm_o_next        = '0;
        end else begin
          phase_count_next = pc_inc;
          if (pc_inc >= cfg.wait_limit) begin
            done              = 1'b1;
            last_dist_next    = uer_pkg::MAX_CM;
            last_h_next       = uer_pkg::MAX_DIGIT;
            last_t_next       = uer_pkg::MAX_DIGIT;
            last_o_next       = uer_pkg::MAX_DIGIT;
            last_timeout_next = 1'b1;
            phase_next        = after_report;
            phase_count_next  = '0;
          end
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          high_count_next = hc_inc;
          if (sub_count == SUB_LAST) begin
            sub_count_next = '0;
            cm_next        = cm_inc;
            cm_h_next      = cm_h_inc;
            cm_t_next      = cm_t_inc;
            cm_o_next      = cm_o_inc;
          end else begin
            sub_count_next = sub_count + 1'b1;
          end
          if (hc_inc >= cfg.high_limit) begin
            done              = 1'b1;
            last_dist_next    = cm_next;
            last_h_next       = cm_h_next;
            last_t_next       = cm_t_next;
            last_o_next       = cm_o_next;
            last_timeout_next = 1'b0;
            phase_next        = after_report;
            phase_count_next  = '0;
          end
        end else begin
          done              = 1'b1;
          last_dist_next    = cm;
          last_h_next       = cm_h;
          last_t_next       = cm_t;
          last_o_next       = cm_o;
          last_timeout_next = 1'b0;
          phase_next        = after_report;
          phase_count_next  = '0;
        end
      end
      default: begin
        phase_count_next = pc_inc;
        if (pc_inc >= cfg.gap) begin
          phase_next       = PH_TRIG_LOW;
          phase_count_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TRIG_LOW;
      phase_count  <= '0;
      high_count   <= '0;
      sub_count    <= '0;
      cm           <= '0;
      cm_h         <= '0;
      cm_t         <= '0;
      cm_o         <= '0;
      last_dist    <= '0;
      last_h       <= '0;
      last_t       <= '0;
      last_o       <= '0;
      last_timeout <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      phase_count  <= phase_count_next;
      high_count   <= high_count_next;
      sub_count    <= sub_count_next;
      cm           <= cm_next;
      cm_h         <= cm_h_next;
      cm_t         <= cm_t_next;
      cm_o         <= cm_o_next;
      last_dist    <= last_dist_next;
      last_h       <= last_h_next;
      last_t       <= last_t_next;
      last_o       <= last_o_next;
      last_timeout <= last_timeout_next;
    end
  end

  // result of this tick, seen after the state update
  always_comb begin
    res.trigger        = trig;
    res.done_res       = done;
    res.distance_cm    = last_dist_next;
    res.timed_out      = last_timeout_next;
    res.hundreds_digit = last_h_next;
    res.tens_digit     = last_t_next;
    res.ones_digit     = last_o_next;
  end

endmodule
`default_nettype wire

/* src/uer_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uer_out
// Result register: obstacle compare, packing and the master-side handshake.
// ----------------------------------------------------------------------------
module uer_out (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire uer_pkg::result_t                  res,
  input  wire logic [uer_pkg::DIST_W-1:0]        threshold,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [uer_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                   room
);

  localparam int unsigned USED_W = 2 + uer_pkg::DIST_W + 2 + 3 * uer_pkg::DIGIT_W;

  logic obstacle;

  assign obstacle = res.distance_cm < threshold;
  assign room     = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{(uer_pkg::OUT_TDATA_W - USED_W){1'b0}},
                  res.ones_digit, res.tens_digit, res.hundreds_digit,
                  res.timed_out, obstacle, res.distance_cm,
                  res.done_res, res.trigger};
    end
  end

endmodule
`default_nettype wire

/* src/ultrasonic_echo_ranger.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger/echo ranging sequencer for an HC-SR04 style sensor, one item a tick.
// ----------------------------------------------------------------------------
// Feed one input item per 1 us tick carrying the sampled echo level; every
// item yields exactly one result item carrying the trigger level to drive,
// the report strobe and the last distance in cm with its decimal digits,
// obstacle and timeout flags. The sequencer updates its phase and counters
// in a single step and the result lands in one output register, so a new
// item is taken every cycle while results are drained. The echo width is
// turned into centimetres by a running count of 58 ticks per cm in binary
// and decimal, so no divider sits in the path. Write the configuration
// registers only while no item is in flight.
module ultrasonic_echo_ranger (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [0] echo, [7:1] zero
  input  wire logic [uer_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] trigger, [1] done_res, [11:2] distance_cm, [12] obstacle,
  // [13] timed_out, [17:14] hundreds_digit, [21:18] tens_digit,
  // [25:22] ones_digit, [31:26] zero
  output logic [uer_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input  wire logic                             cfg_wen,
  input  wire logic [uer_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [uer_pkg::CNT_W-1:0]        cfg_data
);

  uer_pkg::cfg_t    cfg;
  uer_pkg::result_t res;
  logic             step;
  logic             room;

  assign s_tready = room;
  assign step     = s_tvalid && room;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .echo (s_tdata[0]),
    .cfg  (cfg),
    .res  (res)
  );

  uer_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res       (res),
    .threshold (cfg.threshold),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .room      (room)
  );

  // a report never coincides with the trigger pulse
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("report during trigger pulse");

  // a timeout always carries the saturated distance
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] |-> m_tdata[11:2] == uer_pkg::MAX_CM)
    else $error("timeout without saturated distance");

  // decimal digits agree with the binary distance
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (14'(m_tdata[17:14]) * 14'd100 + 14'(m_tdata[21:18]) * 14'd10
                  + 14'(m_tdata[25:22])) == 14'(m_tdata[11:2]))
    else $error("digits disagree with distance");

  // a new item is taken whenever the result register is free
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
// Streams echo levels in, one item per tick, and keeps its own model of the
// trigger/echo sequencer to forecast every result item. Each result is
// compared field by field. The run covers the trigger held low out of reset,
// all-zero and all-ones registers, an exact high-limit boundary, echo
// timeouts, and random register settings with random pulse trains, with
// random gaps on the input side and random stalls on the output.
module tb;

  localparam int unsigned RUN_LIMIT       = 3_000_000;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned RANDOM_SETTINGS = 5;

  // indexes with no register behind them
  localparam logic [uer_pkg::IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [uer_pkg::IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic [2:0] {
    TRIG_LOW, TRIG_HIGH, ECHO_WAIT, ECHO_MEASURE, CYCLE_GAP
  } ranger_phase_t;

  // layout of m_tdata, lowest field last
  typedef struct packed {
    logic [5:0]                  pad;
    logic [uer_pkg::DIGIT_W-1:0] ones_digit;
    logic [uer_pkg::DIGIT_W-1:0] tens_digit;
    logic [uer_pkg::DIGIT_W-1:0] hundreds_digit;
    logic                        timed_out;
    logic                        obstacle;
    logic [uer_pkg::DIST_W-1:0]  distance_cm;
    logic                        done_res;
    logic                        trigger;
  } range_rpt_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [uer_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [uer_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_wen = 1'b0;
  logic [uer_pkg::IDX_W-1:0]       cfg_index = '0;
  logic [uer_pkg::CNT_W-1:0]       cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ultrasonic_echo_ranger i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sequencer model
  uer_pkg::cfg_t              ranger_cfg;
  ranger_phase_t              ranger_phase;
  logic [uer_pkg::CNT_W-1:0]  ranger_count;
  logic [uer_pkg::CNT_W-1:0]  ranger_high;
  logic [uer_pkg::DIST_W-1:0] ranger_cm;
  logic                       ranger_tmo;

  range_rpt_t  tick_results_due[$];
  int unsigned mismatches = 0;
  int unsigned ticks_checked = 0;
  int unsigned readings_seen = 0;
  int unsigned timeouts_seen = 0;
  int unsigned obstacles_seen = 0;
  bit          idling_on = 1'b1;
  int unsigned stall_left = 0;

  function automatic void reset_ranger();
    ranger_cfg.trig_low   = uer_pkg::RST_TRIG_LOW;
    ranger_cfg.trig_high  = uer_pkg::RST_TRIG_HIGH;
    ranger_cfg.wait_limit = uer_pkg::RST_WAIT_LIM;
    ranger_cfg.high_limit = uer_pkg::RST_HIGH_LIM;
    ranger_cfg.gap        = uer_pkg::RST_GAP;
    ranger_cfg.threshold  = uer_pkg::RST_THRESHOLD;
    ranger_phase = TRIG_LOW;
    ranger_count = '0;
    ranger_high  = '0;
    ranger_cm    = '0;
    ranger_tmo   = 1'b0;
  endfunction

  function automatic void apply_reg_write(input logic [uer_pkg::IDX_W-1:0] idx,
                                          input logic [uer_pkg::CNT_W-1:0] data);
    case (idx)
      uer_pkg::REG_TRIG_LOW:  ranger_cfg.trig_low   = data;
      uer_pkg::REG_TRIG_HIGH: ranger_cfg.trig_high  = data;
      uer_pkg::REG_WAIT_LIM:  ranger_cfg.wait_limit = data;
      uer_pkg::REG_HIGH_LIM:  ranger_cfg.high_limit = data;
      uer_pkg::REG_GAP:       ranger_cfg.gap        = data;
      uer_pkg::REG_THRESHOLD: ranger_cfg.threshold  = data[uer_pkg::DIST_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void enter_phase(input ranger_phase_t p);
    ranger_phase = p;
    ranger_count = '0;
  endfunction

  // a zero limit still ends the phase on its first tick
  function automatic logic count_reached(input logic [uer_pkg::CNT_W-1:0] limit);
    ranger_count = ranger_count + 1'b1;
    return ranger_count >= limit;
  endfunction

  function automatic void log_reading(input int unsigned cm, input logic tmo);
    ranger_cm  = (cm > uer_pkg::MAX_CM) ? uer_pkg::MAX_CM : uer_pkg::DIST_W'(cm);
    ranger_tmo = tmo;
    enter_phase(ranger_cfg.gap == 0 ? TRIG_LOW : CYCLE_GAP);
  endfunction

  function automatic range_rpt_t predict_tick(input logic echo_lvl);
    range_rpt_t r;
    logic       trig;
    logic       done;
    r    = '0;
    trig = 1'b0;
    done = 1'b0;
    case (ranger_phase)
      TRIG_LOW: begin
        if (count_reached(ranger_cfg.trig_low)) enter_phase(TRIG_HIGH);
      end
      TRIG_HIGH: begin
        trig = 1'b1;
        if (count_reached(ranger_cfg.trig_high)) enter_phase(ECHO_WAIT);
      end
      ECHO_WAIT: begin
        // the rising tick itself is not counted
        if (echo_lvl) begin
          ranger_high = '0;
          enter_phase(ECHO_MEASURE);
        end else if (count_reached(ranger_cfg.wait_limit)) begin
          log_reading(uer_pkg::MAX_CM, 1'b1);
          done = 1'b1;
        end
      end
      ECHO_MEASURE: begin
        if (echo_lvl) ranger_high = ranger_high + 1'b1;
        if (!echo_lvl || ranger_high >= ranger_cfg.high_limit) begin
          log_reading(ranger_high / uer_pkg::TICKS_PER_CM, 1'b0);
          done = 1'b1;
        end
      end
      default: begin
        if (count_reached(ranger_cfg.gap)) enter_phase(TRIG_LOW);
      end
    endcase
    r.trigger        = trig;
    r.done_res       = done;
    r.distance_cm    = ranger_cm;
    r.obstacle       = ranger_cm < ranger_cfg.threshold;
    r.timed_out      = ranger_tmo;
    r.hundreds_digit = uer_pkg::DIGIT_W'(ranger_cm / 100);
    r.tens_digit     = uer_pkg::DIGIT_W'((ranger_cm / 10) % 10);
    r.ones_digit     = uer_pkg::DIGIT_W'(ranger_cm % 10);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(input range_rpt_t want, input range_rpt_t got);
    check_field("trigger", 32'(want.trigger), 32'(got.trigger));
    check_field("done_res", 32'(want.done_res), 32'(got.done_res));
    check_field("distance_cm", 32'(want.distance_cm), 32'(got.distance_cm));
    check_field("obstacle", 32'(want.obstacle), 32'(got.obstacle));
    check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
    check_field("hundreds_digit", 32'(want.hundreds_digit), 32'(got.hundreds_digit));
    check_field("tens_digit", 32'(want.tens_digit), 32'(got.tens_digit));
    check_field("ones_digit", 32'(want.ones_digit), 32'(got.ones_digit));
    check_field("tdata pad", 32'(want.pad), 32'(got.pad));
  endfunction

  // forecast on every accepted item, check on every accepted result
  always @(posedge clk) begin
    range_rpt_t want;
    if (rst) begin
      reset_ranger();
    end else begin
      if (s_tvalid && s_tready) tick_results_due.push_back(predict_tick(s_tdata[0]));
      if (m_tvalid && m_tready) begin
        if (tick_results_due.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, m_tdata);
          mismatches++;
        end else begin
          want = tick_results_due.pop_front();
          compare_result(want, m_tdata);
          ticks_checked++;
          if (want.done_res) begin
            readings_seen++;
            if (want.timed_out) timeouts_seen++;
            if (want.obstacle) obstacles_seen++;
          end
        end
      end
      if (cfg_wen) apply_reg_write(cfg_index, cfg_data);
    end
  end

  // mostly short, now and then long
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idling_on && $urandom_range(0, 99) < 20) begin
      stall_left <= idle_length() - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_echo(input logic echo_lvl);
    int unsigned gap;
    gap = (idling_on && $urandom_range(0, 99) < 25) ? idle_length() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(uer_pkg::IN_TDATA_W-1){1'b0}}, echo_lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_level(input logic echo_lvl, input int unsigned n);
    repeat (n) send_echo(echo_lvl);
  endtask

  // hold the source quiet until every result is back, then let the pipe empty
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [uer_pkg::IDX_W-1:0] idx,
                           input logic [uer_pkg::CNT_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_ranger_cfg(input uer_pkg::cfg_t c);
    logic [uer_pkg::CNT_W-1:0] thr_word;
    logic [uer_pkg::CNT_W-1:0] junk;
    // upper bits of the threshold write carry noise and must be dropped
    thr_word = uer_pkg::CNT_W'($urandom());
    thr_word[uer_pkg::DIST_W-1:0] = c.threshold;
    junk = uer_pkg::CNT_W'($urandom());
    write_reg(uer_pkg::REG_TRIG_LOW, c.trig_low);
    write_reg(uer_pkg::REG_TRIG_HIGH, c.trig_high);
    write_reg(uer_pkg::REG_WAIT_LIM, c.wait_limit);
    write_reg(uer_pkg::REG_HIGH_LIM, c.high_limit);
    write_reg(uer_pkg::REG_GAP, c.gap);
    write_reg(uer_pkg::REG_THRESHOLD, thr_word);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, junk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // reset values: the trigger stays low well inside its 1000-tick phase
  task automatic test_reset_defaults();
    idling_on = 1'b1;
    send_level(1'b0, 60);
  endtask

  // every duration and limit acts as one tick, no gap, threshold zero
  task automatic test_zero_registers();
    uer_pkg::cfg_t c;
    c = '0;
    drain_results();
    set_ranger_cfg(c);
    send_level(1'b0, 8);
    send_level(1'b1, 4);
    send_level(1'b0, 3);
  endtask

  // echo held past an exact 2 cm high limit, threshold at 2 and then at 3
  task automatic test_limit_boundaries();
    uer_pkg::cfg_t c;
    c.trig_low   = 18'd1;
    c.trig_high  = 18'd2;
    c.wait_limit = 18'd5;
    c.high_limit = uer_pkg::CNT_W'(2 * uer_pkg::TICKS_PER_CM);
    c.gap        = 18'd3;
    c.threshold  = 10'd2;
    for (int pass = 0; pass < 2; pass++) begin
      drain_results();
      set_ranger_cfg(c);
      send_level(1'b0, 8);
      send_level(1'b1, 130);
      send_level(1'b0, 3);
      c.threshold = 10'd3;
    end
  endtask

  // all-ones registers, then a short trigger and an echo under the widest limits
  task automatic test_full_range();
    uer_pkg::cfg_t c;
    c = '1;
    idling_on = 1'b0;
    drain_results();
    set_ranger_cfg(c);
    c.trig_low  = 18'd2;
    c.trig_high = 18'd1;
    c.gap       = '0;
    set_ranger_cfg(c);
    send_level(1'b0, 20);
    send_level(1'b1, 120);
    send_level(1'b0, 2);
    drain_results();
    idling_on = 1'b1;
  endtask

  task automatic test_random_ranging();
    uer_pkg::cfg_t c;
    bit            far;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   pulses;
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      drain_results();
      far          = (s % 4 == 3);
      c.trig_low   = uer_pkg::CNT_W'($urandom_range(0, 8));
      c.trig_high  = uer_pkg::CNT_W'($urandom_range(0, 8));
      c.wait_limit = uer_pkg::CNT_W'($urandom_range(0, 20));
      c.high_limit = uer_pkg::CNT_W'(far ? $urandom_range(120, 300) : $urandom_range(0, 60));
      c.gap        = uer_pkg::CNT_W'($urandom_range(0, 6));
      c.threshold  = uer_pkg::DIST_W'($urandom_range(0, 1) ? $urandom_range(0, 12)
                                                          : $urandom_range(0, 1023));
      set_ranger_cfg(c);
      idling_on = ($urandom_range(0, 3) != 0);
      pulses = far ? 1 : $urandom_range(1, 3);
      repeat (pulses) begin
        // quiet long enough for the trigger, sometimes past the wait limit
        lo = c.trig_low + c.trig_high + c.gap + $urandom_range(0, c.wait_limit + 4);
        hi = $urandom_range(1, c.high_limit + 20);
        send_level(1'b0, lo);
        send_level(1'b1, hi);
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 10)) send_echo(1'($urandom_range(0, 1)));
      end
      send_level(1'b0, 2);
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Run exceeded %0d cycles", RUN_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_registers();
    test_limit_boundaries();
    test_full_range();
    test_random_ranging();
    drain_results();
    $display("Checked %0d ticks: reset values, zero and all-ones registers, %0d random settings",
             ticks_checked, RANDOM_SETTINGS);
    $display("Readings %0d, echo timeouts %0d, obstacle flags %0d",
             readings_seen, timeouts_seen, obstacles_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* ultrasonic_echo_ranger.f */
src/uer_pkg.sv
src/uer_cfg.sv
src/uer_seq.sv
src/uer_out.sv
src/ultrasonic_echo_ranger.sv
verif/tb.sv
